@@ hdl/p1up_pkg.sv @@
`default_nettype none

package p1up_pkg;

  localparam int POS_W     = 4;
  localparam int MIN_LEN   = 11;
  localparam int SEP_START = 2 + 8;
  localparam int POS_SAT   = 11;

  localparam logic [7:0] LEAD_BYTE = 8'h00;
  localparam logic [7:0] SEP_BYTE  = 8'h00;
  localparam logic [7:0] BT_ONE    = 8'h01;
  localparam logic [7:0] BT_TWO    = 8'h02;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_TOO_SHORT = 3'd1,
    ST_BAD_LEAD  = 3'd2,
    ST_BAD_TYPE  = 3'd3,
    ST_NO_SEP    = 3'd4
  } status_t;

endpackage

`default_nettype wire

@@ hdl/pkcs1_v15_unpad_parser.sv @@
`default_nettype none

// Block-type 1/2 PKCS#1 v1.5 unpadding parser. The encoded message enters one byte per
// item, most significant first, with in_tlast on its final byte. Every byte after the
// first zero separator at position ten or later comes out as a payload item with
// out_tuser set, while the leading byte and block type are good; the final byte always
// yields an item with out_tlast set and the status in out_tdata[10:8]. Other bytes yield
// no item. The block accepts one item every cycle while out_tready does not stall the output;
// an item passes an input register and the header/separator flag update into the result
// register. in_tready follows out_tready combinationally through the two register stages,
// and state returns to reset after each final byte.
module pkcs1_v15_unpad_parser (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // msg_byte[7:0]
  input  wire logic        in_tlast,   // last_byte
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [15:0]      out_tdata,  // payload_byte[7:0], status[10:8], zero[15:11]
  output logic             out_tuser,  // payload_valid
  output logic             out_tlast   // end_of_message
);

  localparam int PW = p1up_pkg::POS_W;

  logic                 s1_valid_r;
  logic [7:0]           s1_byte_r;
  logic                 s1_last_r;
  logic                 s1_adv;

  logic [PW-1:0]        pos_r, pos_nxt;
  logic                 lead_bad_r, lead_bad_nxt;
  logic                 type_bad_r, type_bad_nxt;
  logic                 sep_r, sep_nxt;

  logic                 out_valid_r;
  logic [7:0]           payload_r;
  logic                 pvalid_r;
  logic                 eom_r;
  p1up_pkg::status_t    status_r;

  logic                 in_sep_zone;
  logic                 lead_bad_c, type_bad_c;
  logic                 payload_c;
  logic                 emit_c;
  p1up_pkg::status_t    status_c;

  assign s1_adv    = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || s1_adv;

  always_comb begin
    in_sep_zone = pos_r >= PW'(p1up_pkg::SEP_START);
    lead_bad_c  = (pos_r == '0) ? (s1_byte_r != p1up_pkg::LEAD_BYTE) : lead_bad_r;
    type_bad_c  = (pos_r == PW'(1)) ?
                  !(s1_byte_r == p1up_pkg::BT_ONE || s1_byte_r == p1up_pkg::BT_TWO) :
                  type_bad_r;
    payload_c   = in_sep_zone && sep_r && !lead_bad_c && !type_bad_c;
    sep_nxt     = sep_r || (in_sep_zone && (s1_byte_r == p1up_pkg::SEP_BYTE));
    emit_c      = payload_c || s1_last_r;

    status_c = p1up_pkg::ST_OK;
    if (s1_last_r) begin
      if (pos_r < PW'(p1up_pkg::MIN_LEN - 1)) begin
        status_c = p1up_pkg::ST_TOO_SHORT;
      end else if (lead_bad_c) begin
        status_c = p1up_pkg::ST_BAD_LEAD;
      end else if (type_bad_c) begin
        status_c = p1up_pkg::ST_BAD_TYPE;
      end else if (!sep_nxt) begin
        status_c = p1up_pkg::ST_NO_SEP;
      end
    end

    pos_nxt      = (pos_r < PW'(p1up_pkg::POS_SAT)) ? pos_r + PW'(1) : pos_r;
    lead_bad_nxt = lead_bad_c;
    type_bad_nxt = type_bad_c;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      pos_r       <= '0;
      lead_bad_r  <= 1'b0;
      type_bad_r  <= 1'b0;
      sep_r       <= 1'b0;
    end else begin
      if (in_tready) begin
        s1_valid_r <= in_tvalid;
      end
      if (s1_adv) begin
        out_valid_r <= emit_c;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      if (s1_adv) begin
        if (s1_last_r) begin
          pos_r      <= '0;
          lead_bad_r <= 1'b0;
          type_bad_r <= 1'b0;
          sep_r      <= 1'b0;
        end else begin
          pos_r      <= pos_nxt;
          lead_bad_r <= lead_bad_nxt;
          type_bad_r <= type_bad_nxt;
          sep_r      <= sep_nxt;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_byte_r <= in_tdata;
      s1_last_r <= in_tlast;
    end
    if (s1_adv) begin
      payload_r <= payload_c ? s1_byte_r : 8'h00;
      pvalid_r  <= payload_c;
      eom_r     <= s1_last_r;
      status_r  <= status_c;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'b0, status_r, payload_r};
  assign out_tuser  = pvalid_r;
  assign out_tlast  = eom_r;

  a_no_empty_item: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (pvalid_r || eom_r))
    else $error("result item carries neither payload nor end of message");

  a_status_only_at_end: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !eom_r) |-> (status_r == p1up_pkg::ST_OK))
    else $error("nonzero status on a result that is not the final one");

  a_pos_sat: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r <= PW'(p1up_pkg::POS_SAT))
    else $error("byte position ran past its saturation value");

  a_reset_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_adv && s1_last_r) |=> (pos_r == '0 && !sep_r && !lead_bad_r && !type_bad_r))
    else $error("parser state not cleared after the final byte");

endmodule

`default_nettype wire

@@ tb/sv/testbench.sv @@
`timescale 1ns / 1ps

module testbench;

  localparam int CYCLE_LIMIT = 200000;
  localparam int TARGET_BYTES = 950;
  localparam int HOLD_AFTER = 500;

  typedef struct packed {
    logic [7:0] value;
    logic       last;
    logic       hold;
  } msg_byte_t;

  typedef struct packed {
    logic [7:0]        data;
    logic              valid;
    logic              eom;
    p1up_pkg::status_t status;
  } unpad_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = 8'h00;
  logic        in_tlast = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;
  logic        out_tuser;
  logic        out_tlast;

  msg_byte_t      tx_bytes[$];
  unpad_result_t  pending_results[$];

  logic [p1up_pkg::POS_W-1:0] msg_pos = '0;
  logic                       lead_bad = 1'b0;
  logic                       type_bad = 1'b0;
  logic                       sep_seen = 1'b0;

  logic in_fire = 1'b0;
  int   cycle_count = 0;
  int   mismatches = 0;
  int   bytes_in = 0;
  int   payload_count = 0;
  int   status_count[5] = '{default: 0};
  logic calm;

  pkcs1_v15_unpad_parser uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  assign calm = (cycle_count >= 300) && (cycle_count < 600);

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("check failed: %s got %0d expected %0d (cycle %0d)", what, got, want,
             cycle_count);
    mismatches++;
  endtask

  // Tracks header and separator state and queues the item, if any, that each byte produces.
  task automatic unpad_step(input logic [7:0] b, input logic last);
    unpad_result_t r;
    logic          payload;
    payload = 1'b0;
    if (msg_pos == 0) begin
      lead_bad = (b != p1up_pkg::LEAD_BYTE);
    end else if (msg_pos == 1) begin
      type_bad = !(b == p1up_pkg::BT_ONE || b == p1up_pkg::BT_TWO);
    end else if (msg_pos >= p1up_pkg::SEP_START) begin
      if (sep_seen) begin
        payload = 1'b1;
      end else if (b == p1up_pkg::SEP_BYTE) begin
        sep_seen = 1'b1;
      end
    end
    if (lead_bad || type_bad) begin
      payload = 1'b0;
    end
    r.status = p1up_pkg::ST_OK;
    if (last) begin
      if (int'(msg_pos) + 1 < p1up_pkg::MIN_LEN) r.status = p1up_pkg::ST_TOO_SHORT;
      else if (lead_bad) r.status = p1up_pkg::ST_BAD_LEAD;
      else if (type_bad) r.status = p1up_pkg::ST_BAD_TYPE;
      else if (!sep_seen) r.status = p1up_pkg::ST_NO_SEP;
    end
    if (msg_pos < p1up_pkg::POS_SAT) begin
      msg_pos = msg_pos + 1'b1;
    end
    if (payload || last) begin
      r.data = payload ? b : 8'h00;
      r.valid = payload;
      r.eom = last;
      pending_results.push_back(r);
    end
    if (last) begin
      msg_pos = '0;
      lead_bad = 1'b0;
      type_bad = 1'b0;
      sep_seen = 1'b0;
    end
  endtask

  task automatic push_byte(input logic [7:0] v, input logic last, input logic hold);
    msg_byte_t m;
    m.value = v;
    m.last = last;
    m.hold = hold;
    tx_bytes.push_back(m);
  endtask

  // Mostly well-formed messages with random content; some have broken headers,
  // no separator, or are too short.
  task automatic add_random_message(input logic hold_first);
    int         len;
    int         sep_at;
    int         pick;
    logic [7:0] v;
    pick = $urandom_range(9);
    if (pick == 0) len = $urandom_range(1, 10);
    else if (pick == 1) len = $urandom_range(25, 40);
    else len = $urandom_range(11, 24);
    sep_at = $urandom_range(p1up_pkg::SEP_START, len);
    if ($urandom_range(5) == 0) sep_at = len;
    for (int i = 0; i < len; i++) begin
      pick = $urandom_range(9);
      if (i == 0) begin
        v = (pick == 0) ? 8'($urandom_range(1, 255)) : p1up_pkg::LEAD_BYTE;
      end else if (i == 1) begin
        if (pick == 0) v = 8'($urandom);
        else if (pick < 5) v = p1up_pkg::BT_ONE;
        else v = p1up_pkg::BT_TWO;
      end else if (i < p1up_pkg::SEP_START) begin
        v = (pick < 3) ? p1up_pkg::SEP_BYTE : 8'($urandom);
      end else if (i < sep_at) begin
        v = 8'($urandom_range(1, 255));
      end else if (i == sep_at) begin
        v = p1up_pkg::SEP_BYTE;
      end else begin
        v = 8'($urandom);
      end
      push_byte(v, i == len - 1, hold_first && i == 0);
    end
  endtask

  always @(negedge clk) begin
    out_tready <= calm || ($urandom_range(99) >= 14);
    if (rst_n && (!in_tvalid || in_fire)) begin
      if (tx_bytes.size() != 0
          && !(tx_bytes[0].hold && pending_results.size() != 0)
          && (calm || $urandom_range(99) >= 14)) begin
        in_tvalid <= 1'b1;
        in_tdata <= tx_bytes[0].value;
        in_tlast <= tx_bytes[0].last;
        void'(tx_bytes.pop_front());
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    unpad_result_t want;
    cycle_count <= cycle_count + 1;
    if (!rst_n) begin
      in_fire <= 1'b0;
    end else begin
      in_fire <= in_tvalid && in_tready;
      if (out_tvalid && out_tready) begin
        if (pending_results.size() == 0) begin
          report_mismatch("unexpected item, tdata", out_tdata, 0);
        end else begin
          want = pending_results.pop_front();
          if (out_tdata[7:0] != want.data)
            report_mismatch("payload_byte", out_tdata[7:0], want.data);
          if (out_tuser != want.valid)
            report_mismatch("payload_valid", out_tuser, want.valid);
          if (out_tlast != want.eom)
            report_mismatch("end_of_message", out_tlast, want.eom);
          if (out_tdata[10:8] != want.status)
            report_mismatch("status", out_tdata[10:8], want.status);
          if (out_tdata[15:11] != 5'd0)
            report_mismatch("tdata padding", out_tdata[15:11], 0);
          if (want.valid) payload_count++;
          if (want.eom) status_count[want.status]++;
        end
      end
      if (in_tvalid && in_tready) begin
        unpad_step(in_tdata, in_tlast);
        bytes_in++;
      end
    end
  end

  always @(posedge clk) begin
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("pkcs1_v15_unpad_parser: mismatch");
      $finish;
    end
  end

  initial begin
    logic held;
    held = 1'b0;

    // A single 0xFF byte: too short.
    push_byte(8'hFF, 1'b1, 1'b0);
    // Minimal good message whose final byte is the separator: ok, empty payload.
    push_byte(p1up_pkg::LEAD_BYTE, 1'b0, 1'b0);
    push_byte(p1up_pkg::BT_TWO, 1'b0, 1'b0);
    for (int i = 0; i < 8; i++) push_byte(8'hFF, 1'b0, 1'b0);
    push_byte(p1up_pkg::SEP_BYTE, 1'b1, 1'b0);
    // Zero bytes in the skipped region must not count as the separator.
    push_byte(p1up_pkg::LEAD_BYTE, 1'b0, 1'b0);
    push_byte(p1up_pkg::BT_ONE, 1'b0, 1'b0);
    for (int i = 0; i < 8; i++) push_byte(8'h00, 1'b0, 1'b0);
    push_byte(p1up_pkg::SEP_BYTE, 1'b0, 1'b0);
    push_byte(8'hFF, 1'b0, 1'b0);
    push_byte(8'h00, 1'b1, 1'b0);

    while (tx_bytes.size() < TARGET_BYTES) begin
      add_random_message(!held && tx_bytes.size() >= HOLD_AFTER);
      if (tx_bytes.size() >= HOLD_AFTER) held = 1'b1;
    end

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    while (tx_bytes.size() != 0 || in_tvalid) @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("Sent %0d bytes; checked %0d payload bytes.", bytes_in, payload_count);
    $display("Message endings: ok %0d, short %0d, bad lead %0d, bad type %0d, no sep %0d.",
             status_count[p1up_pkg::ST_OK], status_count[p1up_pkg::ST_TOO_SHORT],
             status_count[p1up_pkg::ST_BAD_LEAD], status_count[p1up_pkg::ST_BAD_TYPE],
             status_count[p1up_pkg::ST_NO_SEP]);
    if (mismatches == 0) begin
      $display("pkcs1_v15_unpad_parser: match");
    end else begin
      $display("pkcs1_v15_unpad_parser: mismatch");
    end
    $finish;
  end

endmodule
